// ----- sv/bst_pkg.sv -----
// bst_pkg: shared types and constants of the bitmap slot table.
// Transfer payloads, request and status codes, controller states and the
// command/status structs between controller and datapath. No dependencies.
package bst_pkg;

    localparam int DEF_CAPACITY   = 256;
    localparam int DEF_DATA_WIDTH = 64;

    localparam int ROW_BITS = 8;
    localparam int ROW_SH   = 3;
    localparam int BYTE_SH  = 3;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;

    localparam logic [8:0] RST_CAPACITY = 9'd256;
    localparam logic [3:0] RST_ELEM     = 4'd8;
    localparam logic       RST_POINTER  = 1'b0;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CAPACITY = 2'd0,
        CFG_ELEM     = 2'd1,
        CFG_POINTER  = 2'd2
    } t_cfg_idx;

    typedef enum logic [2:0] {
        REQ_PUT     = 3'd0,
        REQ_SET     = 3'd1,
        REQ_SET_TRY = 3'd2,
        REQ_GET     = 3'd3,
        REQ_REMOVE  = 3'd4
    } t_req_type;

    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_SIZE  = 3'd1,
        ST_INDEX = 3'd2,
        ST_FAIL  = 3'd3,
        ST_FULL  = 3'd4
    } t_status;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [7:0]  slot_index;
        logic [3:0]  size_bytes;
        logic [63:0] write_data;
    } t_in;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  result_index;
        logic [63:0] read_data;
        logic [8:0]  live_count;
    } t_out;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DECIDE,
        S_SCAN,
        S_PUT_WR
    } t_state;

    typedef enum logic [1:0] {
        FIN_NONE,
        FIN_REQ,
        FIN_PUT_WR,
        FIN_PUT_FAIL
    } t_fin;

    typedef struct packed {
        logic clear;
        logic load;
        logic scan_step;
        logic take_slot;
        t_fin fin;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic in_is_put;
        logic out_free;
        logic put_early;
        logic row_found;
        logic row_last;
    } t_sts;

endpackage

// ----- sv/bst_ctrl.sv -----
// bst_ctrl: sequencing state machine of the bitmap slot table.
// Depends on bst_pkg for states, commands and datapath status.
module bst_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  bst_pkg::t_sts i_sts,
    output bst_pkg::t_cmd o_cmd,
    output logic          o_in_stall
);

    bst_pkg::t_state r_state;
    bst_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bst_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state         = r_state;
        o_cmd.clear     = 1'b0;
        o_cmd.load      = 1'b0;
        o_cmd.scan_step = 1'b0;
        o_cmd.take_slot = 1'b0;
        o_cmd.fin       = bst_pkg::FIN_NONE;
        o_in_stall      = 1'b1;
        unique case (r_state)
            bst_pkg::S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = bst_pkg::S_IDLE;
                end
            end
            bst_pkg::S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_sts.in_is_put ? bst_pkg::S_SCAN : bst_pkg::S_DECIDE;
                end
            end
            bst_pkg::S_DECIDE: begin
                if (i_sts.out_free) begin
                    o_cmd.fin = bst_pkg::FIN_REQ;
                    n_state   = bst_pkg::S_IDLE;
                end
            end
            bst_pkg::S_SCAN: begin
                priority if (i_sts.put_early || (!i_sts.row_found && i_sts.row_last)) begin
                    if (i_sts.out_free) begin
                        o_cmd.fin = bst_pkg::FIN_PUT_FAIL;
                        n_state   = bst_pkg::S_IDLE;
                    end
                end else if (i_sts.row_found) begin
                    o_cmd.take_slot = 1'b1;
                    n_state         = bst_pkg::S_PUT_WR;
                end else begin
                    o_cmd.scan_step = 1'b1;
                end
            end
            bst_pkg::S_PUT_WR: begin
                if (i_sts.out_free) begin
                    o_cmd.fin = bst_pkg::FIN_PUT_WR;
                    n_state   = bst_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = bst_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ----- sv/bst_dpath.sv -----
// bst_dpath: slot memory, occupancy row memory, configuration, live count
// and the result register of the bitmap slot table. Depends on bst_pkg.
module bst_dpath #(
    parameter int CAPACITY   = bst_pkg::DEF_CAPACITY,
    parameter int DATA_WIDTH = bst_pkg::DEF_DATA_WIDTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  bst_pkg::t_in                   i_in_data,
    input  logic                           i_out_stall,
    input  logic                           i_cfg_we,
    input  logic [bst_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bst_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  bst_pkg::t_cmd                  i_cmd,
    output bst_pkg::t_sts                  o_sts,
    output logic                           o_out_valid,
    output bst_pkg::t_out                  o_out_data
);

    localparam int AW      = $clog2(CAPACITY);
    localparam int ROWS    = (CAPACITY + bst_pkg::ROW_BITS - 1) / bst_pkg::ROW_BITS;
    localparam int RAW     = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int WB      = DATA_WIDTH / 8;
    localparam int CAP_LIM = (CAPACITY > 511) ? 511 : CAPACITY;
    localparam int CMPW    = ((AW > 9) ? AW : 9) + 1;
    localparam int SLW     = RAW + bst_pkg::ROW_SH;

    logic [DATA_WIDTH-1:0]        mem_data [CAPACITY];
    logic [bst_pkg::ROW_BITS-1:0] mem_occ  [ROWS];

    logic [8:0] r_cfg_cap;
    logic [3:0] r_cfg_elem;
    logic       r_cfg_ptr;

    bst_pkg::t_in                 r_in;
    logic [AW-1:0]                r_addr;
    logic [AW-1:0]                n_addr;
    logic [RAW-1:0]               r_row;
    logic [RAW-1:0]               n_row;
    logic [AW-1:0]                r_clr;
    logic [8:0]                   r_count;
    logic [8:0]                   n_count;
    logic [DATA_WIDTH-1:0]        r_rd_data;
    logic [bst_pkg::ROW_BITS-1:0] r_rd_occ;
    logic                         r_out_valid;
    bst_pkg::t_out                r_out;
    bst_pkg::t_out                n_out;

    logic [8:0]                   cap;
    logic [3:0]                   eb;
    logic [3:0]                   nbytes;
    logic                         size_bad;
    logic                         idx_bad;
    logic                         idx_occ;
    logic [DATA_WIDTH-1:0]        wmask;
    logic [DATA_WIDTH-1:0]        merged;
    logic                         row_found;
    logic [bst_pkg::ROW_SH-1:0]   found_bit;
    logic [SLW-1:0]               found_slot;
    logic                         row_last;
    logic [bst_pkg::ROW_SH-1:0]   bit_pos;
    logic                         data_we;
    logic [AW-1:0]                data_waddr;
    logic [DATA_WIDTH-1:0]        data_wdata;
    logic                         occ_we;
    logic [RAW-1:0]               occ_waddr;
    logic [bst_pkg::ROW_BITS-1:0] occ_wdata;
    logic                         wr_slot;
    logic                         clr_slot;
    logic                         out_free;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_cap  <= bst_pkg::RST_CAPACITY;
            r_cfg_elem <= bst_pkg::RST_ELEM;
            r_cfg_ptr  <= bst_pkg::RST_POINTER;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                bst_pkg::CFG_CAPACITY: r_cfg_cap  <= i_cfg_data;
                bst_pkg::CFG_ELEM:     r_cfg_elem <= i_cfg_data[3:0];
                bst_pkg::CFG_POINTER:  r_cfg_ptr  <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    assign cap      = (r_cfg_cap > 9'(CAP_LIM)) ? 9'(CAP_LIM) : r_cfg_cap;
    assign eb       = (r_cfg_elem > 4'(WB)) ? 4'(WB) : r_cfg_elem;
    assign nbytes   = (r_in.size_bytes > 4'(WB)) ? 4'(WB) : r_in.size_bytes;
    assign size_bad = !r_cfg_ptr && (r_in.size_bytes > eb);
    assign idx_bad  = {1'b0, r_in.slot_index} >= cap;
    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        for (int k = 0; k < DATA_WIDTH; k++) begin
            wmask[k] = r_cfg_ptr || ((k >> bst_pkg::BYTE_SH) < int'(nbytes));
        end
    end

    assign merged = (r_rd_data & ~wmask) | (DATA_WIDTH'(r_in.write_data) & wmask);

    // lowest free usable slot in the current occupancy row
    always_comb begin
        logic [CMPW-1:0] slot_cmp;
        row_found = 1'b0;
        found_bit = '0;
        for (int j = bst_pkg::ROW_BITS - 1; j >= 0; j--) begin
            slot_cmp = CMPW'({r_row, bst_pkg::ROW_SH'(j)});
            if (!r_rd_occ[j] && (slot_cmp < CMPW'(cap))) begin
                row_found = 1'b1;
                found_bit = bst_pkg::ROW_SH'(j);
            end
        end
    end

    assign found_slot = {r_row, found_bit};
    assign row_last   = (r_row == RAW'(ROWS - 1)) ||
                        ((CMPW'({r_row, bst_pkg::ROW_SH'(0)}) + CMPW'(bst_pkg::ROW_BITS))
                         >= CMPW'(cap));

    assign o_sts.clr_last  = (r_clr == AW'(CAPACITY - 1));
    assign o_sts.in_is_put = (i_in_data.req_type == bst_pkg::REQ_PUT);
    assign o_sts.out_free  = out_free;
    assign o_sts.put_early = size_bad || (cap == '0);
    assign o_sts.row_found = row_found;
    assign o_sts.row_last  = row_last;

    // addresses of the next read
    always_comb begin
        n_addr = r_addr;
        n_row  = r_row;
        if (i_cmd.load) begin
            n_addr = AW'(i_in_data.slot_index);
            n_row  = (i_in_data.req_type == bst_pkg::REQ_PUT) ? '0
                                                               : RAW'(i_in_data.slot_index[7:3]);
        end
        if (i_cmd.scan_step) begin
            n_row = r_row + 1'b1;
        end
        if (i_cmd.take_slot) begin
            n_addr = AW'(found_slot);
        end
    end

    assign idx_occ = r_rd_occ[r_in.slot_index[bst_pkg::ROW_SH-1:0]];

    // result and update decision
    always_comb begin
        n_out.status       = bst_pkg::ST_OK;
        n_out.result_index = r_in.slot_index;
        n_out.read_data    = '0;
        n_count            = r_count;
        wr_slot            = 1'b0;
        clr_slot           = 1'b0;
        bit_pos            = r_in.slot_index[bst_pkg::ROW_SH-1:0];
        unique case (i_cmd.fin)
            bst_pkg::FIN_NONE: begin
            end
            bst_pkg::FIN_PUT_FAIL: begin
                n_out.status       = size_bad ? bst_pkg::ST_SIZE : bst_pkg::ST_FULL;
                n_out.result_index = '0;
            end
            bst_pkg::FIN_PUT_WR: begin
                n_out.result_index = 8'(r_addr);
                bit_pos            = r_addr[bst_pkg::ROW_SH-1:0];
                wr_slot            = 1'b1;
                n_count            = r_count + 9'd1;
            end
            bst_pkg::FIN_REQ: begin
                unique case (r_in.req_type)
                    bst_pkg::REQ_SET: begin
                        priority if (size_bad) begin
                            n_out.status = bst_pkg::ST_SIZE;
                        end else if (idx_bad) begin
                            n_out.status = bst_pkg::ST_INDEX;
                        end else begin
                            wr_slot = 1'b1;
                            n_count = r_count + {8'd0, !idx_occ};
                        end
                    end
                    bst_pkg::REQ_SET_TRY: begin
                        priority if (idx_bad) begin
                            n_out.status = bst_pkg::ST_INDEX;
                        end else if (idx_occ) begin
                            n_out.status = bst_pkg::ST_FAIL;
                        end else if (size_bad) begin
                            n_out.status = bst_pkg::ST_SIZE;
                        end else begin
                            wr_slot = 1'b1;
                            n_count = r_count + 9'd1;
                        end
                    end
                    bst_pkg::REQ_GET, bst_pkg::REQ_REMOVE: begin
                        priority if (idx_bad) begin
                            n_out.status = bst_pkg::ST_INDEX;
                        end else if (!idx_occ) begin
                            n_out.status = bst_pkg::ST_FAIL;
                        end else begin
                            n_out.read_data = 64'(r_rd_data);
                            if (r_in.req_type == bst_pkg::REQ_REMOVE) begin
                                clr_slot = 1'b1;
                                n_count  = r_count - 9'd1;
                            end
                        end
                    end
                    default: begin
                        n_out.status = bst_pkg::ST_FAIL;
                    end
                endcase
            end
            default: begin
            end
        endcase
        n_out.live_count = n_count;
    end

    // memory write ports
    always_comb begin
        data_we    = i_cmd.clear || wr_slot;
        data_waddr = i_cmd.clear ? r_clr : r_addr;
        data_wdata = i_cmd.clear ? '0 : merged;
        occ_we     = (i_cmd.clear && (int'(r_clr) < ROWS)) || wr_slot || clr_slot;
        occ_waddr  = i_cmd.clear ? RAW'(r_clr) : r_row;
        occ_wdata  = r_rd_occ;
        occ_wdata[bit_pos] = wr_slot;
        if (i_cmd.clear) begin
            occ_wdata = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (data_we) begin
            mem_data[data_waddr] <= data_wdata;
        end
        r_rd_data <= mem_data[n_addr];
    end

    always_ff @(posedge i_clk) begin
        if (occ_we) begin
            mem_occ[occ_waddr] <= occ_wdata;
        end
        r_rd_occ <= mem_occ[n_row];
    end

    always_ff @(posedge i_clk) begin
        r_addr <= n_addr;
        r_row  <= n_row;
        if (i_cmd.load) begin
            r_in <= i_in_data;
        end
        if (i_cmd.fin != bst_pkg::FIN_NONE) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr       <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clear) begin
                r_clr <= r_clr + 1'b1;
            end
            r_count     <= n_count;
            r_out_valid <= (i_cmd.fin != bst_pkg::FIN_NONE) || (r_out_valid && i_out_stall);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ----- sv/bitmap_slot_table.sv -----
// bitmap_slot_table: top level of the slot table with occupancy bitmap.
// Depends on bst_pkg, bst_ctrl and bst_dpath.
//
// After reset the block runs a clearing pass over the slot memory and the
// occupancy rows and takes no request meanwhile; config writes are taken at
// any time. One request is in work at a time. Set, set_try, get, remove and
// unknown requests finish in the decide state, which uses the registered
// memory read for the update. Put scans the occupancy bitmap one row of 8
// slots per cycle, takes the lowest free usable slot and writes it in the
// put-write state; a size failure or zero capacity ends it at once, a full
// table after the last row. The finished result sits in an output register,
// so the next request is taken while it waits; the block holds only if a
// second result is ready while the first has not yet been taken.
module bitmap_slot_table #(
    parameter int CAPACITY   = bst_pkg::DEF_CAPACITY,
    parameter int DATA_WIDTH = bst_pkg::DEF_DATA_WIDTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  bst_pkg::t_in                   i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output bst_pkg::t_out                  o_out_data,
    input  logic                           i_cfg_we,
    input  logic [bst_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bst_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    bst_pkg::t_cmd cmd;
    bst_pkg::t_sts sts;

    bst_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    bst_dpath #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_out_stall (i_out_stall),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule
